// ===== sv/sdsf_pkg.sv =====
// Shared glyph codes, frame types and digit helpers for the segment formatter.
package sdsf_pkg;

    typedef logic [7:0] glyph_t;
    typedef glyph_t [5:0] frame_t;

    typedef struct packed {
        logic ld0;
        logic ld1;
        logic ld2;
        logic ld3;
    } volt_ctrl_t;

    localparam logic [2:0] MODE_TIME = 3'd0;
    localparam logic [2:0] MODE_DATE = 3'd1;
    localparam logic [2:0] MODE_TEMP = 3'd2;
    localparam logic [2:0] MODE_HUM  = 3'd3;
    localparam logic [2:0] MODE_VOLT = 3'd4;

    localparam glyph_t GLYPH_BLANK  = 8'hFF;
    localparam glyph_t GLYPH_DEGREE = 8'h87;
    localparam glyph_t GLYPH_MINUS  = 8'hF7;
    localparam glyph_t GLYPH_SLASH  = 8'h67;
    localparam glyph_t GLYPH_C      = 8'h1E;
    localparam glyph_t GLYPH_E      = 8'h16;
    localparam glyph_t GLYPH_O      = 8'h72;
    localparam glyph_t GLYPH_R      = 8'h77;
    localparam glyph_t GLYPH_V      = 8'h7A;
    localparam glyph_t DP_MASK      = 8'h02;

    localparam logic [11:0] VOLT_SCALE_RESET = 12'd1200;
    localparam logic [9:0]  CENTI_MAX        = 10'd999;
    localparam logic [6:0]  TWO_DIGIT_MAX    = 7'd99;

    function automatic glyph_t digit_glyph(input logic [3:0] d);
        glyph_t g;
        case (d)
            4'd0:    g = 8'h0A;
            4'd1:    g = 8'hEB;
            4'd2:    g = 8'h46;
            4'd3:    g = 8'hC2;
            4'd4:    g = 8'hA3;
            4'd5:    g = 8'h92;
            4'd6:    g = 8'h12;
            4'd7:    g = 8'hCB;
            4'd8:    g = 8'h02;
            4'd9:    g = 8'h82;
            default: g = GLYPH_BLANK;
        endcase
        return g;
    endfunction

    // Quotient by ten through the reciprocal 205 / 2048, exact below 1029.
    function automatic logic [3:0] div10(input logic [6:0] x);
        logic [14:0] p;
        p = 15'(x) * 15'd205;
        return p[14:11];
    endfunction

    function automatic logic [3:0] mod10(input logic [6:0] x);
        logic [6:0] r;
        r = x - 7'(div10(x)) * 7'd10;
        return r[3:0];
    endfunction

endpackage

// ===== sv/sdsf_if.sv =====
// Request and result channel interfaces of the segment formatter.
interface sdsf_in_if #(parameter int ADC_BITS = 10);
    logic                valid;
    logic                ready;
    logic [2:0]          mode;
    logic                time_valid;
    logic [4:0]          hour;
    logic [5:0]          minute;
    logic [5:0]          second;
    logic [4:0]          day;
    logic [3:0]          month;
    logic [6:0]          year_short;
    logic                sensor_valid;
    logic signed [7:0]   temperature;
    logic [6:0]          humidity;
    logic [ADC_BITS-1:0] battery_sample;

    modport source (
        output valid, mode, time_valid, hour, minute, second, day, month,
               year_short, sensor_valid, temperature, humidity, battery_sample,
        input  ready
    );
    modport sink (
        input  valid, mode, time_valid, hour, minute, second, day, month,
               year_short, sensor_valid, temperature, humidity, battery_sample,
        output ready
    );
endinterface

interface sdsf_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] seg_0;
    logic [7:0] seg_1;
    logic [7:0] seg_2;
    logic [7:0] seg_3;
    logic [7:0] seg_4;
    logic [7:0] seg_5;

    modport source (
        output valid, seg_0, seg_1, seg_2, seg_3, seg_4, seg_5,
        input  ready
    );
    modport sink (
        input  valid, seg_0, seg_1, seg_2, seg_3, seg_4, seg_5,
        output ready
    );
endinterface

// ===== sv/six_digit_segment_formatter_core.sv =====
// Top level of the six-digit seven-segment frame formatter.
//
// Each request on in_ch carries a display mode and the clock, sensor and
// battery readings; each result on out_ch carries six active-low segment
// bytes, seg_0 leftmost. Every request gives exactly one result, in order.
// volt_scale_reg is written through cfg_we and cfg_wdata; the user must
// write it only while no request is in flight; the block does not check.
// The block is a five-stage pipeline, and one request can be taken every
// cycle while out_ch accepts results. The depth is set by the voltage
// path: one multiply stage, two folding stages that divide by the
// converter full scale, and two digit split stages.
// When out_ch stalls, the stages fill up behind the waiting result and
// in_ch drops ready once every stage holds a request; nothing is lost or
// repeated. in_ch is ready whenever no result waits at the output.
// Reset empties the pipeline and loads the scale register with 1200.
module six_digit_segment_formatter_core
    import sdsf_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [11:0]       cfg_wdata,
    sdsf_in_if.sink           in_ch,
    sdsf_out_if.source        out_ch
);

    localparam int STAGES = 5;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] adv;
    logic [11:0]       volt_scale_reg;
    frame_t            frame_reg [STAGES-1];
    logic              volt_sel_reg [STAGES-1];
    frame_t            out_frame_reg;

    frame_t            frame_next;
    frame_t            volt_frame;
    volt_ctrl_t        vctrl;
    glyph_t            units_glyph;
    glyph_t            tenths_glyph;
    glyph_t            hundredths_glyph;

    always_comb
    begin
        adv[STAGES-1] = !vld_reg[STAGES-1] || out_ch.ready;
        for (int i = STAGES - 2; i >= 0; i--)
        begin
            adv[i] = !vld_reg[i] || adv[i+1];
        end
    end

    assign in_ch.ready = adv[0];

    assign vctrl.ld0 = adv[0];
    assign vctrl.ld1 = adv[1];
    assign vctrl.ld2 = adv[2];
    assign vctrl.ld3 = adv[3];

    sdsf_frame u_frame (
        .mode         (in_ch.mode),
        .time_valid   (in_ch.time_valid),
        .hour         (in_ch.hour),
        .minute       (in_ch.minute),
        .second       (in_ch.second),
        .day          (in_ch.day),
        .month        (in_ch.month),
        .year_short   (in_ch.year_short),
        .sensor_valid (in_ch.sensor_valid),
        .temperature  (in_ch.temperature),
        .humidity     (in_ch.humidity),
        .frame        (frame_next)
    );

    sdsf_volt #(
        .ADC_BITS (ADC_BITS)
    ) u_volt (
        .clk              (clk),
        .ctrl             (vctrl),
        .sample           (in_ch.battery_sample),
        .scale            (volt_scale_reg),
        .units_glyph      (units_glyph),
        .tenths_glyph     (tenths_glyph),
        .hundredths_glyph (hundredths_glyph)
    );

    always_comb
    begin
        volt_frame    = {6{GLYPH_BLANK}};
        volt_frame[1] = units_glyph;
        volt_frame[2] = tenths_glyph;
        volt_frame[3] = hundredths_glyph;
        volt_frame[5] = GLYPH_V;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg        <= '0;
            volt_scale_reg <= VOLT_SCALE_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                volt_scale_reg <= cfg_wdata;
            end
            if (adv[0])
            begin
                vld_reg[0] <= in_ch.valid;
            end
            for (int i = 1; i < STAGES; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            frame_reg[0]    <= frame_next;
            volt_sel_reg[0] <= (in_ch.mode == MODE_VOLT);
        end
        for (int i = 1; i < STAGES - 1; i++)
        begin
            if (adv[i])
            begin
                frame_reg[i]    <= frame_reg[i-1];
                volt_sel_reg[i] <= volt_sel_reg[i-1];
            end
        end
        if (adv[STAGES-1])
        begin
            out_frame_reg <= volt_sel_reg[STAGES-2] ? volt_frame : frame_reg[STAGES-2];
        end
    end

    assign out_ch.valid = vld_reg[STAGES-1];
    assign out_ch.seg_0 = out_frame_reg[0];
    assign out_ch.seg_1 = out_frame_reg[1];
    assign out_ch.seg_2 = out_frame_reg[2];
    assign out_ch.seg_3 = out_frame_reg[3];
    assign out_ch.seg_4 = out_frame_reg[4];
    assign out_ch.seg_5 = out_frame_reg[5];

    a_ready_when_output_empty: assert property (
        @(posedge clk) disable iff (!rst_n)
        !out_ch.valid |-> in_ch.ready
    ) else $error("input not ready although no result waits at the output");

    a_request_enters_first_stage: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready) |=> vld_reg[0]
    ) else $error("accepted request missing from the first stage");

    a_cfg_write_lands: assert property (
        @(posedge clk) disable iff (!rst_n)
        cfg_we |=> (volt_scale_reg == $past(cfg_wdata))
    ) else $error("scale register write lost");

    a_no_flow_while_stalled_full: assert property (
        @(posedge clk) disable iff (!rst_n)
        (&vld_reg && !out_ch.ready) |-> !in_ch.ready
    ) else $error("request taken while every stage is full and stalled");

endmodule

// ===== sv/sdsf_frame.sv =====
// Frame builder for the clock, date, temperature, humidity and error displays.
module sdsf_frame
    import sdsf_pkg::*;
(
    input  logic              [2:0] mode,
    input  logic                    time_valid,
    input  logic              [4:0] hour,
    input  logic              [5:0] minute,
    input  logic              [5:0] second,
    input  logic              [4:0] day,
    input  logic              [3:0] month,
    input  logic              [6:0] year_short,
    input  logic                    sensor_valid,
    input  logic signed       [7:0] temperature,
    input  logic              [6:0] humidity,
    output frame_t                  frame
);

    logic [7:0] traw;
    logic [7:0] tmag;
    logic [6:0] tsat;
    logic [6:0] hsat;
    logic [6:0] pa;
    logic [6:0] pb;
    logic [6:0] pc;
    frame_t     pairs;
    frame_t     err;

    assign traw = $unsigned(temperature);
    assign tmag = traw[7] ? (8'd0 - traw) : traw;
    assign tsat = (tmag > 8'(TWO_DIGIT_MAX)) ? TWO_DIGIT_MAX : tmag[6:0];
    assign hsat = (humidity > TWO_DIGIT_MAX) ? TWO_DIGIT_MAX : humidity;

    assign pa = (mode == MODE_DATE) ? 7'(day) : 7'(hour);
    assign pb = (mode == MODE_DATE) ? 7'(month) : 7'(minute);
    assign pc = (mode == MODE_DATE) ? year_short : 7'(second);

    always_comb
    begin
        pairs[0] = digit_glyph(div10(pa));
        pairs[1] = digit_glyph(mod10(pa));
        pairs[2] = digit_glyph(div10(pb));
        pairs[3] = digit_glyph(mod10(pb));
        pairs[4] = digit_glyph(div10(pc));
        pairs[5] = digit_glyph(mod10(pc));

        err[0] = GLYPH_E;
        err[1] = GLYPH_R;
        err[2] = GLYPH_R;
        err[3] = GLYPH_O;
        err[4] = GLYPH_R;
        err[5] = GLYPH_BLANK;

        frame = {6{GLYPH_BLANK}};
        case (mode)
            MODE_TIME:
            begin
                frame = time_valid ? pairs : err;
            end
            MODE_DATE:
            begin
                frame = pairs;
                frame[1] = pairs[1] & ~DP_MASK;
                frame[3] = pairs[3] & ~DP_MASK;
                if (!time_valid)
                begin
                    frame = err;
                end
            end
            MODE_TEMP:
            begin
                if (!sensor_valid)
                begin
                    frame = err;
                end
                else
                begin
                    if (tsat > 7'd9)
                    begin
                        frame[1] = traw[7] ? GLYPH_MINUS : GLYPH_BLANK;
                        frame[2] = digit_glyph(div10(tsat));
                    end
                    else
                    begin
                        frame[2] = traw[7] ? GLYPH_MINUS : GLYPH_BLANK;
                    end
                    frame[3] = digit_glyph(mod10(tsat));
                    frame[4] = GLYPH_DEGREE;
                    frame[5] = GLYPH_C;
                end
            end
            MODE_HUM:
            begin
                if (!sensor_valid)
                begin
                    frame = err;
                end
                else
                begin
                    if (hsat > 7'd9)
                    begin
                        frame[0] = digit_glyph(div10(hsat));
                    end
                    frame[1] = digit_glyph(mod10(hsat));
                    frame[3] = GLYPH_DEGREE;
                    frame[4] = GLYPH_SLASH;
                    frame[5] = GLYPH_O;
                end
            end
            default:
            begin
                frame = {6{GLYPH_BLANK}};
            end
        endcase
    end

endmodule

// ===== sv/sdsf_volt.sv =====
// Pipelined battery voltage scaling, division by full scale and digit split.
module sdsf_volt
    import sdsf_pkg::*;
#(
    parameter int ADC_BITS = 10
)
(
    input  logic                clk,
    input  volt_ctrl_t          ctrl,
    input  logic [ADC_BITS-1:0] sample,
    input  logic [11:0]         scale,
    output glyph_t              units_glyph,
    output glyph_t              tenths_glyph,
    output glyph_t              hundredths_glyph
);

    localparam int PW  = ADC_BITS + 12;
    localparam int RW  = ((ADC_BITS > 12) ? ADC_BITS : 12) + 1;
    localparam int QW  = RW - ADC_BITS;
    localparam int R1W = ADC_BITS + 1;
    localparam logic [R1W-1:0] FULL = {1'b0, {ADC_BITS{1'b1}}};

    logic [PW-1:0]  prod_reg;
    logic [11:0]    q0_reg;
    logic [RW-1:0]  rem_a_reg;
    logic [9:0]     centi_reg;
    logic [3:0]     units_reg;
    logic [6:0]     low_reg;

    logic [QW-1:0]  q1;
    logic [R1W-1:0] rem_b;
    logic           corr;
    logic [12:0]    quot;
    logic [9:0]     centi_next;
    logic [15:0]    hund_prod;
    logic [3:0]     units_next;
    logic [9:0]     low_wide;

    // Full scale is 2^N - 1, so each pass folds the high part back onto the low part.
    assign q1    = rem_a_reg[RW-1:ADC_BITS];
    assign rem_b = R1W'(rem_a_reg[ADC_BITS-1:0]) + R1W'(q1);
    assign corr  = (rem_b >= FULL);
    assign quot  = 13'(q0_reg) + 13'(q1) + 13'(corr);
    assign centi_next = (quot > 13'(CENTI_MAX)) ? CENTI_MAX : quot[9:0];

    assign hund_prod  = 16'(centi_reg) * 16'd41;
    assign units_next = hund_prod[15:12];
    assign low_wide   = centi_reg - 10'(units_next) * 10'd100;

    always_ff @(posedge clk)
    begin
        if (ctrl.ld0)
        begin
            prod_reg <= PW'(sample) * PW'(scale);
        end
        if (ctrl.ld1)
        begin
            q0_reg    <= prod_reg[PW-1:ADC_BITS];
            rem_a_reg <= RW'(prod_reg[ADC_BITS-1:0]) + RW'(prod_reg[PW-1:ADC_BITS]);
        end
        if (ctrl.ld2)
        begin
            centi_reg <= centi_next;
        end
        if (ctrl.ld3)
        begin
            units_reg <= units_next;
            low_reg   <= low_wide[6:0];
        end
    end

    assign units_glyph      = digit_glyph(units_reg) & ~DP_MASK;
    assign tenths_glyph     = digit_glyph(div10(low_reg));
    assign hundredths_glyph = digit_glyph(mod10(low_reg));

endmodule
